>>> hdl/cp1251_pkg.sv
package cp1251_pkg;

    // Lengths of a UTF-8 run
    localparam logic [1:0] RUN_LEN_1 = 2'd1;
    localparam logic [1:0] RUN_LEN_2 = 2'd2;
    localparam logic [1:0] RUN_LEN_3 = 2'd3;

    // Byte slots within a run
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    // Fixed lead bytes and offsets for the Cyrillic letter blocks
    localparam logic [7:0] LETTER_LO_FIRST = 8'hC0;
    localparam logic [7:0] LETTER_LO_LAST  = 8'hEF;
    localparam logic [7:0] LETTER_HI_FIRST = 8'hF0;
    localparam logic [7:0] LEAD_LO         = 8'hD0;
    localparam logic [7:0] LEAD_HI         = 8'hD1;
    localparam logic [7:0] OFFSET_LO       = 8'h30;
    localparam logic [7:0] OFFSET_HI       = 8'h70;

    // Code points of bytes 0x80..0xBF; zero marks the unassigned byte
    localparam logic [15:0] HIGH_TABLE [0:63] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
    };

    // One encoded character: up to three bytes and the run length
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] len;
        logic       valid;
    } enc_t;

    function automatic enc_t encode(input logic [7:0] b);
        enc_t        e;
        logic [15:0] cp;
        e.b0    = 8'h00;
        e.b1    = 8'h00;
        e.b2    = 8'h00;
        e.len   = RUN_LEN_1;
        e.valid = 1'b1;
        cp      = HIGH_TABLE[b[5:0]];
        priority if (!b[7])
        begin
            e.b0 = b;
        end
        else if (b >= LETTER_LO_FIRST && b <= LETTER_LO_LAST)
        begin
            e.b0  = LEAD_LO;
            e.b1  = b - OFFSET_LO;
            e.len = RUN_LEN_2;
        end
        else if (b >= LETTER_HI_FIRST)
        begin
            e.b0  = LEAD_HI;
            e.b1  = b - OFFSET_HI;
            e.len = RUN_LEN_2;
        end
        else if (cp == 16'h0000)
        begin
            e.valid = 1'b0;
        end
        else if (cp < 16'h0800)
        begin
            e.b0  = {3'b110, cp[10:6]};
            e.b1  = {2'b10, cp[5:0]};
            e.len = RUN_LEN_2;
        end
        else
        begin
            e.b0  = {4'b1110, cp[15:12]};
            e.b1  = {2'b10, cp[11:6]};
            e.b2  = {2'b10, cp[5:0]};
            e.len = RUN_LEN_3;
        end
        return e;
    endfunction

endpackage

>>> hdl/cp1251_to_utf8_transcoder.sv
// Windows-1251 to UTF-8 transcoder.
// Input: pulse start with in_byte and in_end; the word is taken at a clock
// edge where start is high and busy is low. Each input character is looked
// up and stored as a run of one to three UTF-8 bytes in a run register.
// Output: one result word per cycle, marked by strobe, with out_byte,
// byte_valid, run_last and text_end. Bytes of a run come on consecutive
// cycles; run_last marks the last one, and text_end repeats in_end there.
// The unassigned byte 0x98 gives one word with byte_valid low and a zero
// byte.
// The first byte of a run passes through the run register and then the
// output register. One input is taken per cycle for one-byte characters
// while start is high; a run of two or three bytes holds busy high until
// its last byte, as the output has one byte lane. busy is low in the cycle
// that loads the last byte of a run into the output register, so the next
// character loads without a gap.
// The receiver cannot stall; every strobe word must be taken as it comes.
// Reset empties the run register and clears the strobe; no word is pending
// after it.
module cp1251_to_utf8_transcoder
    import cp1251_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       busy,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       text_end
);

    enc_t       enc_reg;
    enc_t       enc_next;
    logic       full_reg;
    logic       full_next;
    logic       end_reg;
    logic       end_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;

    logic       strobe_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       byte_valid_reg;
    logic       run_last_reg;
    logic       text_end_reg;

    logic       last_now;
    logic       accept;
    logic [7:0] cur_byte;

    // Detect the final byte of the current run
    assign last_now = full_reg && (idx_reg == (enc_reg.len - RUN_LEN_1));
    assign busy     = full_reg && !last_now;
    assign accept   = start && !busy;

    // Pick the byte of the run at the current slot
    always_comb
    begin
        unique case (idx_reg)
            SLOT_0:  cur_byte = enc_reg.b0;
            SLOT_1:  cur_byte = enc_reg.b1;
            SLOT_2:  cur_byte = enc_reg.b2;
            default: cur_byte = 8'h00;
        endcase
    end

    // Load a new run, advance within a run, or drop a finished one
    always_comb
    begin
        enc_next  = enc_reg;
        end_next  = end_reg;
        full_next = full_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            enc_next  = encode(in_byte);
            end_next  = in_end;
            full_next = 1'b1;
            idx_next  = SLOT_0;
        end
        else if (last_now)
        begin
            full_next = 1'b0;
            idx_next  = SLOT_0;
        end
        else if (full_reg)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    assign out_byte_next = enc_reg.valid ? cur_byte : 8'h00;

    // Hold run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 1'b0;
            idx_reg    <= SLOT_0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            full_reg   <= full_next;
            idx_reg    <= idx_next;
            strobe_reg <= full_reg;
        end
    end

    // Hold run payload and the result word
    always_ff @(posedge clk)
    begin
        enc_reg        <= enc_next;
        end_reg        <= end_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= enc_reg.valid;
        run_last_reg   <= last_now;
        text_end_reg   <= last_now && end_reg;
    end

    assign strobe     = strobe_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign run_last   = run_last_reg;
    assign text_end   = text_end_reg;

endmodule

>>> hdl/cp1251_checker.sv
module cp1251_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       run_last,
    input logic       text_end
);

    // End of text only on the last word of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && text_end |-> run_last)
        else $error("text_end without run_last");

    // Unassigned character gives a single empty word
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !byte_valid |-> run_last && (out_byte == 8'h00))
        else $error("bad empty word");

    // First byte of a run is strobed after each acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 strobe)
        else $error("missing first byte");

    // Bytes of a run come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !run_last |=> strobe)
        else $error("gap inside a run");

    // Busy means more bytes are on their way
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe && !run_last || strobe && run_last)
        else $error("busy without output");

endmodule

bind cp1251_to_utf8_transcoder cp1251_checker u_cp1251_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .strobe     (strobe),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end)
);
